### sv/llwt_pkg.sv
package llwt_pkg;

  // Fixed widths of the scan word; they cover a table of up to 256 entries.
  localparam int TGT_W  = 9;   // target entry, also holds a fill pointer of 256
  localparam int IDX_W  = 8;   // entry index carried with a hit
  localparam int LOAD_W = 16;
  localparam int PID_W  = 32;
  localparam int HND_W  = 32;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_PICK   = 3'd1,
    KIND_UPDATE = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Word that walks down the cell chain: the command plus the best hit so far.
  typedef struct packed {
    logic              valid;
    logic [2:0]        kind;
    logic [PID_W-1:0]  pid;
    logic [HND_W-1:0]  handle;
    logic [TGT_W-1:0]  target;
    logic              unload;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [LOAD_W-1:0] load;
    logic [PID_W-1:0]  hit_pid;
    logic [HND_W-1:0]  hit_handle;
  } scan_t;

  // Saturating count step: down stops at zero, up stops at all ones.
  function automatic logic [LOAD_W-1:0] load_step(input logic [LOAD_W-1:0] load,
                                                  input logic unload);
    logic [LOAD_W-1:0] res;
    res = load;
    if (unload) begin
      if (load != '0) res = load - 1'b1;
    end else begin
      if (load != '1) res = load + 1'b1;
    end
    return res;
  endfunction

endpackage

### sv/llwt_if.sv
interface llwt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] process_id;
  logic [31:0] handle_in;
  logic [3:0]  entry_index;
  logic        unload;

  modport source (output valid, kind, process_id, handle_in, entry_index, unload,
                  input ready);
  modport sink (input valid, kind, process_id, handle_in, entry_index, unload,
                output ready);
endinterface

interface llwt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  chosen_index;
  logic [15:0] load_out;
  logic [31:0] process_id_out;
  logic [31:0] handle_out;

  modport source (output valid, status, chosen_index, load_out, process_id_out,
                  handle_out, input ready);
  modport sink (input valid, status, chosen_index, load_out, process_id_out,
                handle_out, output ready);
endinterface

### sv/llwt_cell.sv
module llwt_cell #(
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           active,
  input  llwt_pkg::scan_t word_in,
  output llwt_pkg::scan_t word_out
);
  import llwt_pkg::*;

  logic [PID_W-1:0]  pid;
  logic [HND_W-1:0]  handle;
  logic [LOAD_W-1:0] load;
  logic [PID_W-1:0]  pid_next;
  logic [HND_W-1:0]  handle_next;
  logic [LOAD_W-1:0] load_next;
  scan_t             word_next;
  logic              hit_target;

  assign hit_target = active && (word_in.target == TGT_W'(INDEX));

  always_comb begin
    pid_next    = pid;
    handle_next = handle;
    load_next   = load;
    word_next   = word_in;
    if (word_in.valid && active) begin
      case (word_in.kind)
        KIND_INSERT: begin
          if (hit_target) begin
            pid_next    = word_in.pid;
            handle_next = word_in.handle;
            word_next.found      = 1'b1;
            word_next.idx        = IDX_W'(INDEX);
            word_next.load       = load;
            word_next.hit_pid    = word_in.pid;
            word_next.hit_handle = word_in.handle;
          end
        end
        KIND_PICK: begin
          // strict less-than keeps the lowest index on ties
          if (!word_in.found || (load < word_in.load)) begin
            word_next.found      = 1'b1;
            word_next.idx        = IDX_W'(INDEX);
            word_next.load       = load;
            word_next.hit_pid    = pid;
            word_next.hit_handle = handle;
          end
        end
        KIND_UPDATE: begin
          if (hit_target) begin
            load_next = load_step(load, word_in.unload);
            word_next.found      = 1'b1;
            word_next.idx        = IDX_W'(INDEX);
            word_next.load       = load_next;
            word_next.hit_pid    = pid;
            word_next.hit_handle = handle;
          end
        end
        KIND_FIND: begin
          if (!word_in.found && (pid == word_in.pid)) begin
            word_next.found      = 1'b1;
            word_next.idx        = IDX_W'(INDEX);
            word_next.load       = load;
            word_next.hit_pid    = pid;
            word_next.hit_handle = handle;
          end
        end
        KIND_READ: begin
          if (hit_target) begin
            word_next.found      = 1'b1;
            word_next.idx        = IDX_W'(INDEX);
            word_next.load       = load;
            word_next.hit_pid    = pid;
            word_next.hit_handle = handle;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pid      <= '0;
      handle   <= '0;
      load     <= '0;
      word_out <= '0;
    end else begin
      pid      <= pid_next;
      handle   <= handle_next;
      load     <= load_next;
      word_out <= word_next;
    end
  end

endmodule

### sv/least_loaded_worker_table.sv
// A word walks the cell chain one entry per cycle, registered in each cell, then
//   into the result register; the next word is taken only once it exits.
// Reset (rst, synchronous): all entries zero, fill pointer zero, worker_count
//   zero, chain and result register empty.
module least_loaded_worker_table #(
  parameter int MAX_WORKERS = 16
) (
  input  logic            clk,
  input  logic            rst,
  llwt_in_if.sink         in_ch,
  llwt_out_if.source      out_ch,
  input  logic            cfg_wr_en,
  input  logic [4:0]      cfg_wr_data
);
  import llwt_pkg::*;

  // Fill pointer and effective count range over 0..MAX_WORKERS.
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  logic [4:0]       worker_count;
  logic [CNT_W-1:0] fill_pointer;
  logic [CNT_W-1:0] active_count;
  logic             busy;
  logic             accept;

  // Chain taps: tap 0 is the launched word, tap i+1 is cell i's output.
  scan_t            chain [MAX_WORKERS+1];
  logic [MAX_WORKERS-1:0] active;
  scan_t            tail;

  // Result register
  logic              res_valid;
  logic [1:0]        res_status;
  logic [3:0]        res_index;
  logic [LOAD_W-1:0] res_load;
  logic [PID_W-1:0]  res_pid;
  logic [HND_W-1:0]  res_handle;
  logic [1:0]        res_status_next;
  logic [3:0]        res_index_next;
  logic [LOAD_W-1:0] res_load_next;
  logic [PID_W-1:0]  res_pid_next;
  logic [HND_W-1:0]  res_handle_next;

  // Effective table size: worker_count capped at the table depth.
  assign active_count = (worker_count < MAX_WORKERS) ? CNT_W'(worker_count)
                                                     : CNT_W'(MAX_WORKERS);

  // One word in flight at a time; the result register is empty by the time
  // the word exits, since it is only taken while that register drains.
  assign in_ch.ready = !busy && (!res_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Launch word: insert targets the fill pointer, others the given entry.
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = accept;
    chain[0].kind   = in_ch.kind;
    chain[0].pid    = in_ch.process_id;
    chain[0].handle = in_ch.handle_in;
    chain[0].unload = in_ch.unload;
    chain[0].target = (in_ch.kind == KIND_INSERT) ? TGT_W'(fill_pointer)
                                                  : TGT_W'(in_ch.entry_index);
  end

  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    assign active[i] = (CNT_W'(i) < active_count);

    llwt_cell #(
      .INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .active  (active[i]),
      .word_in (chain[i]),
      .word_out(chain[i+1])
    );
  end

  assign tail = chain[MAX_WORKERS];

  // Status from the exiting word: a miss means full, none or out of range
  // depending on the command. Unknown commands never hit, so they land on range.
  always_comb begin
    res_index_next  = '0;
    res_load_next   = '0;
    res_pid_next    = '0;
    res_handle_next = '0;
    if (tail.found) begin
      res_status_next = ST_OK;
      res_index_next  = tail.idx[3:0];
      res_load_next   = tail.load;
      res_pid_next    = tail.hit_pid;
      res_handle_next = tail.hit_handle;
    end else begin
      case (tail.kind) inside
        KIND_INSERT:          res_status_next = ST_FULL;
        KIND_PICK, KIND_FIND: res_status_next = ST_NONE;
        default:              res_status_next = ST_RANGE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= '0;
      fill_pointer <= '0;
      busy         <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        worker_count <= cfg_wr_data;
      end
      if (tail.valid && tail.found && (tail.kind == KIND_INSERT)) begin
        fill_pointer <= CNT_W'(fill_pointer + 1'b1);
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
      if (tail.valid) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (tail.valid) begin
      res_status <= res_status_next;
      res_index  <= res_index_next;
      res_load   <= res_load_next;
      res_pid    <= res_pid_next;
      res_handle <= res_handle_next;
    end
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.status         = res_status;
  assign out_ch.chosen_index   = res_index;
  assign out_ch.load_out       = res_load;
  assign out_ch.process_id_out = res_pid;
  assign out_ch.handle_out     = res_handle;

endmodule
